@@ src/jpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jpr_pkg
// Shared constants, codes and types of the Jacobi pressure relaxation block.
// ----------------------------------------------------------------------------
package jpr_pkg;

    localparam int GRID_DIM    = 32;
    localparam int DIM_W       = $clog2(GRID_DIM);
    localparam int GRID_CELLS  = GRID_DIM * GRID_DIM;
    localparam int CELL_W      = 2 * DIM_W;
    localparam int DATA_W      = 32;
    localparam int TOL_W       = 31;
    localparam int SWEEP_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CUBE_SHIFT  = 3 * DIM_W;
    localparam int DEN_SHIFT   = CUBE_SHIFT + 2;
    localparam int SUM_W       = DATA_W + 2;
    localparam int NUM_W       = SUM_W + CUBE_SHIFT + 1;
    localparam int Q_W         = NUM_W - DEN_SHIFT;
    localparam int WIN_LEN     = 2 * GRID_DIM;
    localparam int STREAM_LAST = GRID_CELLS + GRID_DIM - 1;
    localparam int CNT_W       = $clog2(STREAM_LAST + 1);
    localparam int DRAIN_LAST  = 3;
    localparam int DRAIN_W     = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        MODE_WR_RES  = 2'd0,
        MODE_WR_CORR = 2'd1,
        MODE_RUN     = 2'd2,
        MODE_RD_CORR = 2'd3
    } jpr_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWEEP_COUNT = 2'd0,
        CFG_TOLERANCE   = 2'd1
    } jpr_cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } jpr_state_t;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] addr;
    } jpr_tag_t;

endpackage : jpr_pkg
`default_nettype wire

@@ src/jpr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : jpr_ram
`default_nettype wire

@@ src/jpr_update.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jpr_update
// Three-stage cell update: neighbor sum, scaled residual with rounding and
// saturation, then the change test against the tolerance.
// ----------------------------------------------------------------------------
module jpr_update (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire jpr_pkg::jpr_tag_t             in_tag,
    input  wire logic [jpr_pkg::DATA_W-1:0]    self_val,
    input  wire logic [jpr_pkg::DATA_W-1:0]    up_val,
    input  wire logic [jpr_pkg::DATA_W-1:0]    down_val,
    input  wire logic [jpr_pkg::DATA_W-1:0]    left_val,
    input  wire logic [jpr_pkg::DATA_W-1:0]    right_val,
    input  wire logic [jpr_pkg::DATA_W-1:0]    res_val,
    input  wire logic [jpr_pkg::TOL_W-1:0]     tolerance,
    output jpr_pkg::jpr_tag_t                  wr_tag,
    output logic      [jpr_pkg::DATA_W-1:0]    wr_value,
    output logic                               over
);
    import jpr_pkg::*;

    logic [DIM_W-1:0]        row;
    logic [DIM_W-1:0]        col;
    logic [DATA_W-1:0]       up_sel;
    logic [DATA_W-1:0]       down_sel;
    logic [DATA_W-1:0]       left_sel;
    logic [DATA_W-1:0]       right_sel;
    logic signed [SUM_W-1:0] sum_next;

    jpr_tag_t                a_tag_reg;
    logic signed [SUM_W-1:0] a_sum_reg;
    logic [DATA_W-1:0]       a_self_reg;
    logic [DATA_W-1:0]       a_res_reg;

    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] quo;
    logic [DATA_W-1:0]       sat_next;

    jpr_tag_t                b_tag_reg;
    logic [DATA_W-1:0]       b_next_reg;
    logic [DATA_W-1:0]       b_self_reg;

    logic signed [DATA_W:0]  diff;
    logic [DATA_W:0]         diff_abs;

    // stage A: replace neighbors outside the grid by the cell itself
    assign row       = in_tag.addr[CELL_W-1:DIM_W];
    assign col       = in_tag.addr[DIM_W-1:0];
    assign up_sel    = (row == '0) ? self_val : up_val;
    assign down_sel  = (row == '1) ? self_val : down_val;
    assign left_sel  = (col == '0) ? self_val : left_val;
    assign right_sel = (col == '1) ? self_val : right_val;
    assign sum_next  = SUM_W'($signed(up_sel)) + SUM_W'($signed(down_sel))
                     + SUM_W'($signed(left_sel)) + SUM_W'($signed(right_sel));

    // stage B: round half up, then saturate
    assign num = (NUM_W'(a_sum_reg) <<< CUBE_SHIFT) - NUM_W'($signed(a_res_reg))
               + (NUM_W'(1) <<< (DEN_SHIFT - 1));
    assign quo = num >>> DEN_SHIFT;

    always_comb
    begin
        if (quo[Q_W-1] != quo[DATA_W-1])
        begin
            sat_next = quo[Q_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            sat_next = quo[DATA_W-1:0];
        end
    end

    // stage C: change test
    assign diff     = (DATA_W+1)'($signed(b_self_reg)) - (DATA_W+1)'($signed(b_next_reg));
    assign diff_abs = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
    assign over     = b_tag_reg.valid && (diff_abs > (DATA_W+1)'(tolerance));
    assign wr_tag   = b_tag_reg;
    assign wr_value = b_next_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= '0;
            b_tag_reg <= '0;
        end
        else
        begin
            a_tag_reg <= in_tag;
            b_tag_reg <= a_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sum_reg      <= sum_next;
        a_self_reg     <= self_val;
        a_res_reg      <= res_val;
        b_next_reg     <= sat_next;
        b_self_reg     <= a_self_reg;
    end

endmodule : jpr_update
`default_nettype wire

@@ src/jacobi_pressure_relaxation.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_pressure_relaxation
// Jacobi relaxation of a 32x32 pressure-correction grid held in RAM.
//
//  channel   dir  fields
//  s_*       in   tuser: mode; tdata: cell_index[9:0], cell_value[41:10]
//  m_*       out  tdata: read_value[31:0], converged[32]
//  cfg_*     in   index 0 sweep_count, index 1 tolerance
//
// After reset the residual RAM and the current correction bank are zeroed,
// with s_tready low. Cell writes take one request per cycle while results
// are taken; a cell read passes through ST_READ for the registered RAM read.
// A run streams the grid once per sweep through a two-row window, since the
// correction RAM has a single read port. A stalled result blocks requests.
// ----------------------------------------------------------------------------
module jacobi_pressure_relaxation (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // cell_index [9:0], cell_value [41:10], zeros above
    input  wire logic [jpr_pkg::IN_TDATA_W-1:0]    s_tdata,
    // mode [1:0]
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // read_value [31:0], converged [32], zeros above
    output logic      [jpr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [jpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [jpr_pkg::TOL_W-1:0]         cfg_data
);
    import jpr_pkg::*;

    jpr_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DRAIN_W-1:0]   drain_reg, drain_next;
    logic [SWEEP_W-1:0]   sweeps_reg, sweeps_next;
    logic                 bank_reg, bank_next;
    logic                 done_reg, done_next;
    logic                 strm_v_reg;
    logic [CNT_W-1:0]     strm_pos_reg;
    logic [SWEEP_W-1:0]   sweep_count_reg;
    logic [TOL_W-1:0]     tolerance_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [DATA_W-1:0]    win_reg [0:WIN_LEN-1];

    jpr_mode_t            mode;
    logic [CELL_W-1:0]    cell_index;
    logic [DATA_W-1:0]    cell_value;
    logic                 accept;
    logic                 out_free;

    logic                 cur_we;
    logic [CELL_W-1:0]    cur_waddr;
    logic [DATA_W-1:0]    cur_wdata;
    logic                 res_we;
    logic [CELL_W-1:0]    res_waddr;
    logic [DATA_W-1:0]    res_wdata;
    logic [CELL_W-1:0]    corr_raddr;
    logic [CELL_W-1:0]    res_raddr;
    logic [DATA_W-1:0]    res_rdata;
    logic [DATA_W-1:0]    bank0_rdata;
    logic [DATA_W-1:0]    bank1_rdata;
    logic [DATA_W-1:0]    corr_rdata;

    jpr_tag_t             upd_tag;
    jpr_tag_t             wr_tag;
    logic [DATA_W-1:0]    wr_value;
    logic                 over;

    assign mode       = jpr_mode_t'(s_tuser);
    assign cell_index = s_tdata[CELL_W-1:0];
    assign cell_value = s_tdata[CELL_W+DATA_W-1:CELL_W];
    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign corr_rdata = bank_reg ? bank1_rdata : bank0_rdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg[CELL_W-1:0] == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && mode == MODE_RD_CORR)
                begin
                    state_next = ST_READ;
                end
                else if (accept && mode == MODE_RUN)
                begin
                    state_next = (sweep_count_reg == '0) ? ST_DONE : ST_SWEEP;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (cnt_reg == CNT_W'(STREAM_LAST))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    state_next = (sweeps_reg == SWEEP_W'(1)) ? ST_DONE : ST_SWEEP;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control and counters
    always_comb
    begin
        cnt_next       = cnt_reg;
        drain_next     = drain_reg;
        sweeps_next    = sweeps_reg;
        bank_next      = bank_reg;
        done_next      = done_reg;
        cur_we         = 1'b0;
        cur_waddr      = cell_index;
        cur_wdata      = cell_value;
        res_we         = 1'b0;
        res_waddr      = cell_index;
        res_wdata      = cell_value;
        corr_raddr     = cell_index;
        res_raddr      = cnt_reg[CELL_W-1:0] - CELL_W'(GRID_DIM);
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (wr_tag.valid && over)
        begin
            done_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                cur_we    = 1'b1;
                cur_waddr = cnt_reg[CELL_W-1:0];
                cur_wdata = '0;
                res_we    = 1'b1;
                res_waddr = cnt_reg[CELL_W-1:0];
                res_wdata = '0;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next    = '0;
                    sweeps_next = sweep_count_reg;
                    done_next   = 1'b1;
                    unique case (mode)
                        MODE_WR_RES:  res_we = 1'b1;
                        MODE_WR_CORR: cur_we = 1'b1;
                        default:      ;
                    endcase
                    if (mode == MODE_WR_RES || mode == MODE_WR_CORR)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next  = OUT_TDATA_W'(corr_rdata);
            end
            ST_SWEEP:
            begin
                corr_raddr = cnt_reg[CELL_W-1:0];
                cnt_next   = cnt_reg + CNT_W'(1);
                drain_next = DRAIN_W'(DRAIN_LAST);
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - DRAIN_W'(1);
                if (drain_reg == '0)
                begin
                    bank_next   = !bank_reg;
                    sweeps_next = sweeps_reg - SWEEP_W'(1);
                    cnt_next    = '0;
                    if (sweeps_reg != SWEEP_W'(1))
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({done_reg, {DATA_W{1'b0}}});
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // window taps feed the update pipeline once the row below is in
    assign upd_tag.valid = strm_v_reg && (strm_pos_reg >= CNT_W'(GRID_DIM));
    assign upd_tag.addr  = strm_pos_reg[CELL_W-1:0] - CELL_W'(GRID_DIM);

    jpr_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (upd_tag),
        .self_val  (win_reg[GRID_DIM-1]),
        .up_val    (win_reg[WIN_LEN-1]),
        .down_val  (corr_rdata),
        .left_val  (win_reg[GRID_DIM]),
        .right_val (win_reg[GRID_DIM-2]),
        .res_val   (res_rdata),
        .tolerance (tolerance_reg),
        .wr_tag    (wr_tag),
        .wr_value  (wr_value),
        .over      (over)
    );

    jpr_ram #(.WIDTH(DATA_W), .DEPTH(GRID_CELLS)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    jpr_ram #(.WIDTH(DATA_W), .DEPTH(GRID_CELLS)) u_bank0_ram (
        .clk   (clk),
        .we    (bank_reg ? wr_tag.valid : cur_we),
        .waddr (bank_reg ? wr_tag.addr : cur_waddr),
        .wdata (bank_reg ? wr_value : cur_wdata),
        .raddr (corr_raddr),
        .rdata (bank0_rdata)
    );

    jpr_ram #(.WIDTH(DATA_W), .DEPTH(GRID_CELLS)) u_bank1_ram (
        .clk   (clk),
        .we    (bank_reg ? cur_we : wr_tag.valid),
        .waddr (bank_reg ? cur_waddr : wr_tag.addr),
        .wdata (bank_reg ? cur_wdata : wr_value),
        .raddr (corr_raddr),
        .rdata (bank1_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            cnt_reg         <= '0;
            drain_reg       <= '0;
            sweeps_reg      <= '0;
            bank_reg        <= 1'b0;
            done_reg        <= 1'b0;
            strm_v_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            sweep_count_reg <= SWEEP_W'(20);
            tolerance_reg   <= TOL_W'(7);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            drain_reg     <= drain_next;
            sweeps_reg    <= sweeps_next;
            bank_reg      <= bank_next;
            done_reg      <= done_next;
            strm_v_reg    <= (state_reg == ST_SWEEP);
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SWEEP_COUNT: sweep_count_reg <= cfg_data[SWEEP_W-1:0];
                    CFG_TOLERANCE:   tolerance_reg   <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // shift the window one cell per streamed read
    always_ff @(posedge clk)
    begin
        strm_pos_reg <= cnt_reg;
        out_data_reg <= out_data_next;
        if (strm_v_reg)
        begin
            win_reg[0] <= corr_rdata;
            for (int i = 1; i < WIN_LEN; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

endmodule : jacobi_pressure_relaxation
`default_nettype wire

@@ src/jpr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jpr_checker
// Port-level checks of the Jacobi pressure relaxation block.
// ----------------------------------------------------------------------------
module jpr_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [jpr_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic [1:0]                        s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [jpr_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import jpr_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // drop requests while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result stalled");

    // a residual write answers next cycle with zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == MODE_WR_RES
        |=> m_tvalid && m_tdata == '0)
        else $error("residual write result wrong");

    // a correction read holds off requests in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == MODE_RD_CORR |=> !s_tready)
        else $error("request taken during cell read");

endmodule : jpr_checker

bind jacobi_pressure_relaxation jpr_checker u_jpr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
